>>> design/mpk_pkg.sv
package mpk_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;

  // token kinds
  localparam logic [3:0] K_NIL      = 4'd0;
  localparam logic [3:0] K_BOOL     = 4'd1;
  localparam logic [3:0] K_UINT     = 4'd2;
  localparam logic [3:0] K_INT      = 4'd3;
  localparam logic [3:0] K_F32      = 4'd4;
  localparam logic [3:0] K_F64      = 4'd5;
  localparam logic [3:0] K_STR      = 4'd6;
  localparam logic [3:0] K_BIN      = 4'd7;
  localparam logic [3:0] K_ARRAY    = 4'd8;
  localparam logic [3:0] K_MAP      = 4'd9;
  localparam logic [3:0] K_EXT      = 4'd10;
  localparam logic [3:0] K_PAYLOAD  = 4'd11;
  localparam logic [3:0] K_TRUNC    = 4'd12;
  localparam logic [3:0] K_RESERVED = 4'd13;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [63:0] token_value;
    logic [7:0]  extension_type;
    logic        payload_last;
  } token_t;

endpackage

>>> design/mpk_core.sv
module mpk_core #(
  parameter int LENGTH_BITS = mpk_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  mpk_pkg::in_item_t item,
  output logic              res_valid,
  output mpk_pkg::token_t   res
);
  import mpk_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_FIELD, PH_EXTTYPE, PH_PAYLOAD} phase_t;

  // lead byte codes
  localparam logic [7:0] POSFIX_MAX   = 8'h7f;
  localparam logic [7:0] FIXMAP_MIN   = 8'h80;
  localparam logic [7:0] FIXMAP_MAX   = 8'h8f;
  localparam logic [7:0] FIXARR_MIN   = 8'h90;
  localparam logic [7:0] FIXARR_MAX   = 8'h9f;
  localparam logic [7:0] FIXSTR_MIN   = 8'ha0;
  localparam logic [7:0] FIXSTR_MAX   = 8'hbf;
  localparam logic [7:0] NEGFIX_MIN   = 8'he0;
  localparam logic [7:0] MP_NIL       = 8'hc0;
  localparam logic [7:0] MP_RESERVED  = 8'hc1;
  localparam logic [7:0] MP_FALSE     = 8'hc2;
  localparam logic [7:0] MP_TRUE      = 8'hc3;
  localparam logic [7:0] MP_BIN8      = 8'hc4;
  localparam logic [7:0] MP_BIN16     = 8'hc5;
  localparam logic [7:0] MP_BIN32     = 8'hc6;
  localparam logic [7:0] MP_EXT8      = 8'hc7;
  localparam logic [7:0] MP_EXT16     = 8'hc8;
  localparam logic [7:0] MP_EXT32     = 8'hc9;
  localparam logic [7:0] MP_FLOAT32   = 8'hca;
  localparam logic [7:0] MP_FLOAT64   = 8'hcb;
  localparam logic [7:0] MP_UINT8     = 8'hcc;
  localparam logic [7:0] MP_UINT16    = 8'hcd;
  localparam logic [7:0] MP_UINT32    = 8'hce;
  localparam logic [7:0] MP_UINT64    = 8'hcf;
  localparam logic [7:0] MP_INT8      = 8'hd0;
  localparam logic [7:0] MP_INT16     = 8'hd1;
  localparam logic [7:0] MP_INT32     = 8'hd2;
  localparam logic [7:0] MP_INT64     = 8'hd3;
  localparam logic [7:0] MP_FIXEXT1   = 8'hd4;
  localparam logic [7:0] MP_FIXEXT2   = 8'hd5;
  localparam logic [7:0] MP_FIXEXT4   = 8'hd6;
  localparam logic [7:0] MP_FIXEXT8   = 8'hd7;
  localparam logic [7:0] MP_FIXEXT16  = 8'hd8;
  localparam logic [7:0] MP_STR8      = 8'hd9;
  localparam logic [7:0] MP_STR16     = 8'hda;
  localparam logic [7:0] MP_STR32     = 8'hdb;
  localparam logic [7:0] MP_ARRAY16   = 8'hdc;
  localparam logic [7:0] MP_ARRAY32   = 8'hdd;
  localparam logic [7:0] MP_MAP16     = 8'hde;

  function automatic logic [LENGTH_BITS-1:0] sat_len(input logic [63:0] v);
    return (|v[63:LENGTH_BITS]) ? '1 : v[LENGTH_BITS-1:0];
  endfunction

  function automatic logic [63:0] sext_n(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    r = v;
    case (n)
      4'd1: r = {{56{v[7]}},  v[7:0]};
      4'd2: r = {{48{v[15]}}, v[15:0]};
      4'd3: r = {{40{v[23]}}, v[23:0]};
      4'd4: r = {{32{v[31]}}, v[31:0]};
      4'd5: r = {{24{v[39]}}, v[39:0]};
      4'd6: r = {{16{v[47]}}, v[47:0]};
      4'd7: r = {{8{v[55]}},  v[55:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  phase_t                 phase_r,  phase_nxt;
  logic [3:0]             pend_r,   pend_nxt;
  logic [3:0]             left_r,   left_nxt;
  logic [3:0]             size_r,   size_nxt;
  logic [63:0]            acc_r,    acc_nxt;
  logic [LENGTH_BITS-1:0] plen_r,   plen_nxt;

  logic [7:0]             b;
  logic [63:0]            acc_sh;
  logic [3:0]             left_dec;
  logic [LENGTH_BITS-1:0] plen_dec;
  logic [LENGTH_BITS-1:0] len;
  logic                   fld_go;
  logic [3:0]             fld_kind;
  logic [3:0]             fld_size;
  logic                   fix_go;
  logic [4:0]             fix_len;

  assign b        = item.data_byte;
  assign acc_sh   = {acc_r[55:0], b};
  assign left_dec = (left_r != 4'd0) ? left_r - 4'd1 : left_r;
  assign plen_dec = (plen_r != '0) ? plen_r - LENGTH_BITS'(1) : plen_r;

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    left_nxt  = left_r;
    size_nxt  = size_r;
    acc_nxt   = acc_r;
    plen_nxt  = plen_r;
    res_valid = 1'b0;
    res       = '0;
    fld_go    = 1'b0;
    fld_kind  = K_NIL;
    fld_size  = 4'd0;
    fix_go    = 1'b0;
    fix_len   = 5'd0;
    len       = '0;
    if (item.stream_end) begin
      if (phase_r != PH_IDLE) begin
        phase_nxt      = PH_IDLE;
        pend_nxt       = 4'd0;
        left_nxt       = 4'd0;
        size_nxt       = 4'd0;
        acc_nxt        = '0;
        plen_nxt       = '0;
        res_valid      = 1'b1;
        res.token_kind = K_TRUNC;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          res_valid = 1'b1;
          case (b) inside
            [8'h00:POSFIX_MAX]: begin
              res.token_kind  = K_UINT;
              res.token_value = {56'd0, b};
            end
            [NEGFIX_MIN:8'hff]: begin
              res.token_kind  = K_INT;
              res.token_value = {{56{1'b1}}, b};
            end
            [FIXMAP_MIN:FIXMAP_MAX]: begin
              res.token_kind  = K_MAP;
              res.token_value = {60'd0, b[3:0]};
            end
            [FIXARR_MIN:FIXARR_MAX]: begin
              res.token_kind  = K_ARRAY;
              res.token_value = {60'd0, b[3:0]};
            end
            [FIXSTR_MIN:FIXSTR_MAX]: begin
              len             = sat_len({59'd0, b[4:0]});
              pend_nxt        = K_STR;
              plen_nxt        = len;
              phase_nxt       = (len != '0) ? PH_PAYLOAD : PH_IDLE;
              res.token_kind  = K_STR;
              res.token_value = 64'(len);
            end
            MP_NIL:      res.token_kind = K_NIL;
            MP_RESERVED: begin
              res.token_kind  = K_RESERVED;
              res.token_value = {56'd0, b};
            end
            MP_FALSE:    res.token_kind = K_BOOL;
            MP_TRUE: begin
              res.token_kind  = K_BOOL;
              res.token_value = 64'd1;
            end
            MP_BIN8:     begin fld_go = 1'b1; fld_kind = K_BIN;   fld_size = 4'd1; end
            MP_BIN16:    begin fld_go = 1'b1; fld_kind = K_BIN;   fld_size = 4'd2; end
            MP_BIN32:    begin fld_go = 1'b1; fld_kind = K_BIN;   fld_size = 4'd4; end
            MP_EXT8:     begin fld_go = 1'b1; fld_kind = K_EXT;   fld_size = 4'd1; end
            MP_EXT16:    begin fld_go = 1'b1; fld_kind = K_EXT;   fld_size = 4'd2; end
            MP_EXT32:    begin fld_go = 1'b1; fld_kind = K_EXT;   fld_size = 4'd4; end
            MP_FLOAT32:  begin fld_go = 1'b1; fld_kind = K_F32;   fld_size = 4'd4; end
            MP_FLOAT64:  begin fld_go = 1'b1; fld_kind = K_F64;   fld_size = 4'd8; end
            MP_UINT8:    begin fld_go = 1'b1; fld_kind = K_UINT;  fld_size = 4'd1; end
            MP_UINT16:   begin fld_go = 1'b1; fld_kind = K_UINT;  fld_size = 4'd2; end
            MP_UINT32:   begin fld_go = 1'b1; fld_kind = K_UINT;  fld_size = 4'd4; end
            MP_UINT64:   begin fld_go = 1'b1; fld_kind = K_UINT;  fld_size = 4'd8; end
            MP_INT8:     begin fld_go = 1'b1; fld_kind = K_INT;   fld_size = 4'd1; end
            MP_INT16:    begin fld_go = 1'b1; fld_kind = K_INT;   fld_size = 4'd2; end
            MP_INT32:    begin fld_go = 1'b1; fld_kind = K_INT;   fld_size = 4'd4; end
            MP_INT64:    begin fld_go = 1'b1; fld_kind = K_INT;   fld_size = 4'd8; end
            MP_FIXEXT1:  begin fix_go = 1'b1; fix_len = 5'd1; end
            MP_FIXEXT2:  begin fix_go = 1'b1; fix_len = 5'd2; end
            MP_FIXEXT4:  begin fix_go = 1'b1; fix_len = 5'd4; end
            MP_FIXEXT8:  begin fix_go = 1'b1; fix_len = 5'd8; end
            MP_FIXEXT16: begin fix_go = 1'b1; fix_len = 5'd16; end
            MP_STR8:     begin fld_go = 1'b1; fld_kind = K_STR;   fld_size = 4'd1; end
            MP_STR16:    begin fld_go = 1'b1; fld_kind = K_STR;   fld_size = 4'd2; end
            MP_STR32:    begin fld_go = 1'b1; fld_kind = K_STR;   fld_size = 4'd4; end
            MP_ARRAY16:  begin fld_go = 1'b1; fld_kind = K_ARRAY; fld_size = 4'd2; end
            MP_ARRAY32:  begin fld_go = 1'b1; fld_kind = K_ARRAY; fld_size = 4'd4; end
            MP_MAP16:    begin fld_go = 1'b1; fld_kind = K_MAP;   fld_size = 4'd2; end
            default:     begin fld_go = 1'b1; fld_kind = K_MAP;   fld_size = 4'd4; end
          endcase
          if (fld_go || fix_go) begin
            res_valid = 1'b0;
          end
        end
        PH_FIELD: begin
          acc_nxt  = acc_sh;
          left_nxt = left_dec;
          if (left_dec == 4'd0) begin
            phase_nxt = PH_IDLE;
            len       = sat_len(acc_sh);
            res_valid = 1'b1;
            case (pend_r) inside
              K_INT: begin
                res.token_kind  = K_INT;
                res.token_value = sext_n(acc_sh, size_r);
              end
              K_UINT, K_F32, K_F64: begin
                res.token_kind  = pend_r;
                res.token_value = acc_sh;
              end
              K_STR, K_BIN: begin
                plen_nxt        = len;
                phase_nxt       = (len != '0) ? PH_PAYLOAD : PH_IDLE;
                res.token_kind  = pend_r;
                res.token_value = 64'(len);
              end
              K_EXT: begin
                // header waits for the type byte
                plen_nxt  = len;
                phase_nxt = PH_EXTTYPE;
                res_valid = 1'b0;
              end
              default: begin
                res.token_kind  = pend_r;
                res.token_value = 64'(len);
              end
            endcase
          end
        end
        PH_EXTTYPE: begin
          phase_nxt          = (plen_r != '0) ? PH_PAYLOAD : PH_IDLE;
          res_valid          = 1'b1;
          res.token_kind     = K_EXT;
          res.token_value    = 64'(plen_r);
          res.extension_type = b;
        end
        PH_PAYLOAD: begin
          plen_nxt = plen_dec;
          if (plen_dec == '0) begin
            phase_nxt = PH_IDLE;
          end
          res_valid        = 1'b1;
          res.token_kind   = K_PAYLOAD;
          res.token_value  = {56'd0, b};
          res.payload_last = (plen_dec == '0);
        end
      endcase
      if (fld_go) begin
        phase_nxt = PH_FIELD;
        pend_nxt  = fld_kind;
        size_nxt  = fld_size;
        left_nxt  = fld_size;
        acc_nxt   = '0;
      end
      if (fix_go) begin
        phase_nxt = PH_EXTTYPE;
        pend_nxt  = K_EXT;
        plen_nxt  = sat_len({59'd0, fix_len});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pend_r  <= 4'd0;
      left_r  <= 4'd0;
      size_r  <= 4'd0;
      acc_r   <= '0;
      plen_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      left_r  <= left_nxt;
      size_r  <= size_nxt;
      acc_r   <= acc_nxt;
      plen_r  <= plen_nxt;
    end
  end

endmodule

>>> design/msgpack_stream_tokenizer.sv
// MessagePack stream tokenizer. Feed the encoded stream one byte per transfer on the in_
// channel (stream_end set marks the end of the stream and carries no byte); tokens leave on
// the out_ channel in stream order, at most one per input byte. Scalars come out as one
// token with the value widened to 64 bits (signed integers sign-extended, floats as raw
// bits); strings, binaries and extensions give a header token with the length (and, for
// extensions, the type byte) followed by one token per payload byte, the last one flagged.
// Array and map headers report their counts only; nesting is not tracked. The byte 0xc1
// gives a reserved token, and stream_end in the middle of a token gives a truncated token
// and returns the tokenizer to its reset state. Lengths above 2^LENGTH_BITS - 1 saturate.
// Throughput is one byte per clock while the output is not stalled: each byte is captured
// in an input register, decoded against the tokenizer state, and its token written to the
// output register, so a token passes the input register and then the output register
// before it is valid on out_. The output register decouples the sides, so while a token
// waits a byte is still taken into an empty input register, and bytes that produce no
// token keep flowing even when the output is stalled.
module msgpack_stream_tokenizer #(
  parameter int LENGTH_BITS = mpk_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mpk_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mpk_pkg::token_t   out_data
);
  import mpk_pkg::*;

  // input stage
  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r;

  // output stage
  logic     out_valid_r, out_valid_nxt;
  token_t   out_tok_r;

  logic     core_res_valid;
  token_t   core_res;
  logic     advance;
  logic     in_fire;
  logic     out_load;

  mpk_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (s1_item_r),
    .res_valid(core_res_valid),
    .res      (core_res)
  );

  // advance the held byte when it makes no token or the output slot frees up
  assign advance  = s1_valid_r && (!core_res_valid || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;
  assign out_load = advance && core_res_valid;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !advance);
  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
    if (out_load) begin
      out_tok_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_tok_r;

endmodule

>>> design/mpk_checker.sv
module mpk_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input mpk_pkg::token_t out_data
);
  import mpk_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("token changed or dropped while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.token_kind <= K_RESERVED)
    else $error("undefined token kind");

  a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.payload_last |-> out_data.token_kind == K_PAYLOAD)
    else $error("last flag on a non-payload token");

  a_small_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == K_TRUNC || out_data.token_kind == K_BOOL)
      |-> out_data.token_value[63:1] == 63'd0)
    else $error("truncated or bool token carries a wide value");

endmodule

bind msgpack_stream_tokenizer mpk_checker u_mpk_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
